@@ hw/rtl/mavg_pkg.sv @@
package mavg_pkg;

    // window length register
    localparam int WIN_W = 7;
    typedef logic [WIN_W-1:0] win_t;
    localparam win_t WIN_RESET = 7'd8;

    // sample queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

endpackage

@@ hw/rtl/mavg_sample_if.sv @@
interface mavg_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ hw/rtl/mavg_average_if.sv @@
interface mavg_average_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

@@ hw/rtl/mavg_cfg_if.sv @@
interface mavg_cfg_if;
    logic               valid;
    logic               ready;
    mavg_pkg::win_t     window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

@@ hw/rtl/mavg_ram.sv @@
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mavg_front.sv @@
module mavg_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mavg_sample_if.sink   samples,
    mavg_sample_if.source queue
);

    logic signed [SAMPLE_BITS-1:0]      q_mem_reg [mavg_pkg::Q_DEPTH];
    logic [mavg_pkg::Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mavg_pkg::Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mavg_pkg::Q_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                               push, pop;

    assign samples.ready = (cnt_reg != mavg_pkg::Q_CNT_W'(mavg_pkg::Q_DEPTH));
    assign queue.valid   = (cnt_reg != '0);
    assign queue.sample  = q_mem_reg[rd_ptr_reg];

    assign push = samples.valid & samples.ready;
    assign pop  = queue.valid & queue.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mavg_pkg::Q_PTR_W'(mavg_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mavg_pkg::Q_PTR_W'(mavg_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= samples.sample;
        end
    end

    // occupancy tracks transfers on both sides; this check covers a push without a pop
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

@@ hw/rtl/mavg_div.sv @@
module mavg_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 7,
    parameter int QUOT_W     = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic                         done,
    output logic signed [QUOT_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  fits;

    // shift in the next dividend bit, trial subtract
    assign rem_sh = {rem_reg, q_reg[DIVIDEND_W-1]};
    assign fits   = (rem_sh >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            neg_next  = dividend[DIVIDEND_W-1];
            rem_next  = '0;
            q_next    = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(rem_sh - {1'b0, divisor})
                            : rem_sh[DIVISOR_W-1:0];
            q_next   = {q_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        if (fin_reg)
        begin
            quot_next = neg_reg ? QUOT_W'(-q_reg) : QUOT_W'(q_reg);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ hw/rtl/mavg_back.sv @@
module mavg_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mavg_pkg::win_t window_length,
    mavg_sample_if.sink    queue,
    mavg_average_if.source averages
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int EXT_W = FILL_W + 1;
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [PTR_W-1:0]              wp_reg, wp_next;
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          avg_valid_reg, avg_valid_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;

    logic [FILL_W-1:0]             eff_win;
    logic [EXT_W-1:0]              wp_ext, fill_ext, oldest_ext;
    logic [PTR_W-1:0]              oldest_idx;
    logic                          drop;
    logic                          pop;
    logic                          ram_we;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          div_start, div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;

    // zero counts as one, above the store depth saturates
    assign eff_win = (window_length == '0) ? FILL_W'(1)
                   : ((32'(window_length) > MAX_WINDOW) ? FILL_W'(MAX_WINDOW)
                                                         : FILL_W'(window_length));

    assign wp_ext     = EXT_W'(wp_reg);
    assign fill_ext   = {1'b0, fill_reg};
    assign oldest_ext = (wp_ext >= fill_ext) ? (wp_ext - fill_ext)
                      : (wp_ext + EXT_W'(MAX_WINDOW) - fill_ext);
    assign oldest_idx = oldest_ext[PTR_W-1:0];

    assign queue.ready = (state_reg == ST_IDLE);
    assign pop         = queue.valid & queue.ready;
    assign ram_we      = (state_reg == ST_READ);
    assign drop        = (fill_reg >= eff_win);
    assign div_start   = (state_reg == ST_START);

    assign averages.valid   = avg_valid_reg;
    assign averages.average = avg_reg;

    mavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (pop),
        .raddr (oldest_idx),
        .rdata (ram_rdata)
    );

    mavg_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (FILL_W),
        .QUOT_W     (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        avg_valid_next = avg_valid_reg;
        avg_next       = avg_reg;
        if (averages.valid && averages.ready)
        begin
            avg_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    sample_next = queue.sample;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // oldest sample has arrived from the store
                wp_next = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (drop)
                begin
                    sum_next = sum_reg + SUM_W'(sample_reg) - SUM_W'($signed(ram_rdata));
                end
                else
                begin
                    sum_next  = sum_reg + SUM_W'(sample_reg);
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!avg_valid_reg || averages.ready)
                begin
                    avg_valid_next = 1'b1;
                    avg_next       = div_quot;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        avg_reg    <= avg_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_WINDOW))
        else $error("fill count beyond store depth");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= PTR_W'(MAX_WINDOW - 1))
        else $error("write pointer beyond store depth");

    a_read_to_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_START))
        else $error("update did not start the divider");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (fill_reg != '0))
        else $error("divide by zero count");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

endmodule

@@ hw/rtl/moving_average_filter.sv @@
// Boxcar moving average. Each sample transfer on `samples` yields exactly one
// transfer on `averages`: the sum of the most recent samples divided by how
// many are held, truncated toward zero. `cfg` writes window_length (reset 8);
// 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW. Write it only
// while the filter is idle. After a shrink one oldest sample leaves per item
// as the new one enters, so the held count stays where it was and the window
// does not narrow. Each item goes through the one-bit-per-cycle restoring
// divider in the back end; items are worked one at a time. A two-entry queue
// sits in front, and a registered output lets the next item start while a
// result waits. No clearing pass at reset.
module moving_average_filter #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    mavg_cfg_if.sink       cfg,
    mavg_sample_if.sink    samples,
    mavg_average_if.source averages
);

    // window length register, always ready for a write transfer
    mavg_pkg::win_t win_reg;

    mavg_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) queue ();

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= mavg_pkg::WIN_RESET;
        end
        else if (cfg.valid)
        begin
            win_reg <= cfg.window_length;
        end
    end

    // front end: takes sample transfers into a short queue
    mavg_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .queue   (queue.source)
    );

    // back end: window store, running sum, divider, output register
    mavg_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (win_reg),
        .queue         (queue.sink),
        .averages      (averages)
    );

endmodule
